FILE: rtl/lcsr_pkg.sv
package lcsr_pkg;

	// Width of one converter reading.
	localparam int RAW_BITS = 24;

	// Fixed widths of the configuration registers, result fields and tick counter.
	localparam int HALF_W = 8;
	localparam int SETTLE_W = 16;
	localparam int TLIM_W = 24;
	localparam int COEF_W = 16;
	localparam int WLIM_W = 15;
	localparam int WEIGHT_W = 25;
	localparam int TICK_W = 16;

	// Divider and difference widths follow from the reading width.
	localparam int MAG_W = RAW_BITS + 1;
	localparam int DIFF_W = RAW_BITS + 2;
	localparam int BIT_CNT_W = $clog2(RAW_BITS + 1);

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 24;

	localparam int ROUND_BIAS = 50;

	localparam logic [HALF_W-1:0] HALF_RST = HALF_W'(1);
	localparam logic [SETTLE_W-1:0] SETTLE_RST = SETTLE_W'(100);
	localparam logic [TLIM_W-1:0] TLIM_RST = TLIM_W'(25000);
	localparam logic [COEF_W-1:0] COEF_RST = COEF_W'(415);
	localparam logic [WLIM_W-1:0] WLIM_RST = WLIM_W'(5000);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_HALF = 3'd0,
		CFG_SETTLE = 3'd1,
		CFG_TLIM = 3'd2,
		CFG_COEF = 3'd3,
		CFG_WLIM = 3'd4
	} cfg_idx_t;

	typedef enum logic [4:0] {
		PH_IDLE = 5'b00001,
		PH_SETTLE = 5'b00010,
		PH_HIGH = 5'b00100,
		PH_LOW = 5'b01000,
		PH_PULSE = 5'b10000
	} phase_t;

	// What the serial sequencer reports for one tick.
	typedef struct packed {
		logic sck;
		logic done;
		logic [RAW_BITS-1:0] raw;
	} rd_t;

endpackage

FILE: rtl/load_cell_serial_reader_tare_top.sv
// Load cell converter reader with tare.
// Input channel (in_valid/in_ready, dout): one beat per prescaler tick, carrying
// the converter's data-out level. Output channel (out_valid/out_ready): one
// beat per input beat, giving the serial clock level, the finished-reading
// flag, the last raw reading, the tare flag and the held weight.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always
// ready; it writes half period, settle time, tare limit, coefficient and
// weight limit, and is meant to be used while no tick is in flight.
// An ordinary tick, or a reading that becomes the tare, shows its result
// beat in the cycle after acceptance. A reading that yields a weight runs the
// restoring divider for a 25-bit quotient, one quotient bit per cycle, and its
// beat appears once the divider is done and the finish state has been passed.
// One tick is in flight at a time: in_ready stays low while the divider runs.
// A stalled receiver holds the output beat and keeps in_ready low until the
// beat is taken; in_ready returns in the same cycle the beat is taken.
// Reset puts the sequencer in idle waiting for data-out low, arms tare
// capture, clears offset, weight and raw reading, and loads the default
// configuration values.
module load_cell_serial_reader_tare_top (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic dout,
	output logic out_valid,
	input logic out_ready,
	output logic sck,
	output logic sample_done,
	output logic [lcsr_pkg::RAW_BITS-1:0] raw_code,
	output logic tare_taken,
	output logic signed [lcsr_pkg::WEIGHT_W-1:0] weight,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [lcsr_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [lcsr_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int DIFF_W = lcsr_pkg::DIFF_W;
	localparam int CMP_W = (lcsr_pkg::RAW_BITS > lcsr_pkg::TLIM_W)
		? lcsr_pkg::RAW_BITS : lcsr_pkg::TLIM_W;
	localparam logic signed [DIFF_W-1:0] W_MIN_D =
		{{(DIFF_W - lcsr_pkg::WEIGHT_W + 1){1'b1}}, {(lcsr_pkg::WEIGHT_W - 1){1'b0}}};

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV = 3'b010,
		ST_FIN = 3'b100
	} st_t;

	st_t st_q;

	logic [lcsr_pkg::HALF_W-1:0] half_q;
	logic [lcsr_pkg::SETTLE_W-1:0] settle_q;
	logic [lcsr_pkg::TLIM_W-1:0] tlim_q;
	logic [lcsr_pkg::COEF_W-1:0] coef_q;
	logic [lcsr_pkg::WLIM_W-1:0] wlim_q;

	logic tare_pending_q;
	logic [lcsr_pkg::RAW_BITS-1:0] offset_q;
	logic [lcsr_pkg::RAW_BITS-1:0] raw_last_q;
	logic signed [lcsr_pkg::WEIGHT_W-1:0] weight_held_q;
	logic neg_q;
	logic [lcsr_pkg::WEIGHT_W-1:0] q_q;
	logic upd_q;

	logic out_valid_q;
	logic sck_q;
	logic done_q;
	logic tared_q;

	logic accept;
	lcsr_pkg::rd_t rd;
	logic is_tare;
	logic signed [DIFF_W-1:0] diff;
	logic [DIFF_W-1:0] diff_abs;
	logic div_start;
	logic div_done;
	logic [lcsr_pkg::MAG_W-1:0] quo;
	logic signed [DIFF_W-1:0] qs, qc;

	assign in_ready = (st_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign accept = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	lcsr_seq u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.tick(accept),
		.dout(dout),
		.half_period_ticks(half_q),
		.settle_ticks(settle_q),
		.rd(rd)
	);

	always_comb begin
		is_tare = tare_pending_q && (CMP_W'(rd.raw) < CMP_W'(tlim_q));
		diff = $signed(DIFF_W'(rd.raw)) - $signed(DIFF_W'(offset_q))
			+ $signed(DIFF_W'(lcsr_pkg::ROUND_BIAS));
		diff_abs = diff[DIFF_W-1] ? (-diff) : diff;
		div_start = accept && rd.done && !is_tare;
	end

	lcsr_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(diff_abs[lcsr_pkg::MAG_W-1:0]),
		.divisor(coef_q),
		.done(div_done),
		.quotient(quo)
	);

	// Restore the sign, clamp at the bottom of the weight range, and
	// compare against the limit before the value is narrowed.
	always_comb begin
		qs = neg_q ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
		qc = (qs < W_MIN_D) ? W_MIN_D : qs;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q <= lcsr_pkg::HALF_RST;
			settle_q <= lcsr_pkg::SETTLE_RST;
			tlim_q <= lcsr_pkg::TLIM_RST;
			coef_q <= lcsr_pkg::COEF_RST;
			wlim_q <= lcsr_pkg::WLIM_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				lcsr_pkg::CFG_HALF: half_q <= cfg_data[lcsr_pkg::HALF_W-1:0];
				lcsr_pkg::CFG_SETTLE: settle_q <= cfg_data[lcsr_pkg::SETTLE_W-1:0];
				lcsr_pkg::CFG_TLIM: tlim_q <= cfg_data[lcsr_pkg::TLIM_W-1:0];
				lcsr_pkg::CFG_COEF: coef_q <= cfg_data[lcsr_pkg::COEF_W-1:0];
				lcsr_pkg::CFG_WLIM: wlim_q <= cfg_data[lcsr_pkg::WLIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			tare_pending_q <= 1'b1;
			offset_q <= '0;
			raw_last_q <= '0;
			weight_held_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					if (accept) begin
						if (rd.done) begin
							raw_last_q <= rd.raw;
							if (is_tare) begin
								tare_pending_q <= 1'b0;
								offset_q <= rd.raw;
							end
						end
						// A weight reading waits for the divider before its beat.
						out_valid_q <= !div_start;
						if (div_start) begin
							st_q <= ST_DIV;
						end
					end else if (out_ready) begin
						out_valid_q <= 1'b0;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						st_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (upd_q) begin
						weight_held_q <= $signed(q_q);
					end
					out_valid_q <= 1'b1;
					st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sck_q <= rd.sck;
			done_q <= rd.done;
			tared_q <= rd.done && is_tare;
			neg_q <= diff[DIFF_W-1];
		end
		if (div_done) begin
			q_q <= qc[lcsr_pkg::WEIGHT_W-1:0];
			upd_q <= qc < $signed(DIFF_W'(wlim_q));
		end
	end

	assign out_valid = out_valid_q;
	assign sck = sck_q;
	assign sample_done = done_q;
	assign raw_code = raw_last_q;
	assign tare_taken = tared_q;
	assign weight = weight_held_q;

`ifndef NO_ASSERTIONS
	a_tare_once: assert property (@(posedge clk) disable iff (!arst_n)
		!tare_pending_q |=> !tare_pending_q)
		else $error("tare capture re-armed after a tare was taken");

	a_tare_needs_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && tared_q) |-> done_q)
		else $error("tare flag on a beat without a finished reading");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_DIV || st_q == ST_FIN) |-> (!in_ready && !out_valid_q))
		else $error("tick accepted or beat shown while the divider result is pending");

	a_fin_follows_div: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_DIV && div_done) |=> (st_q == ST_FIN))
		else $error("divider result was not taken");
`endif

endmodule

FILE: rtl/lcsr_div.sv
module lcsr_div (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [lcsr_pkg::MAG_W-1:0] dividend,
	input logic [lcsr_pkg::COEF_W-1:0] divisor,
	output logic done,
	output logic [lcsr_pkg::MAG_W-1:0] quotient
);

	localparam int CNT_W = $clog2(lcsr_pkg::MAG_W);

	logic busy_q;
	logic done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [lcsr_pkg::COEF_W-1:0] rem_q;
	logic [lcsr_pkg::MAG_W-1:0] quo_q;
	logic [lcsr_pkg::COEF_W-1:0] dvs_q;

	logic [lcsr_pkg::COEF_W:0] rem_sh;
	logic ge;
	logic [lcsr_pkg::COEF_W:0] rem_n;

	// One restoring step per cycle: the dividend shifts out of quo_q as
	// quotient bits shift in.
	always_comb begin
		rem_sh = {rem_q, quo_q[lcsr_pkg::MAG_W-1]};
		ge = rem_sh >= {1'b0, dvs_q};
		rem_n = ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(lcsr_pkg::MAG_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= (divisor == '0) ? lcsr_pkg::COEF_W'(1) : divisor;
		end else if (busy_q) begin
			rem_q <= rem_n[lcsr_pkg::COEF_W-1:0];
			quo_q <= {quo_q[lcsr_pkg::MAG_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quotient = quo_q;

endmodule

FILE: rtl/lcsr_seq.sv
module lcsr_seq (
	input logic clk,
	input logic arst_n,
	input logic tick,
	input logic dout,
	input logic [lcsr_pkg::HALF_W-1:0] half_period_ticks,
	input logic [lcsr_pkg::SETTLE_W-1:0] settle_ticks,
	output lcsr_pkg::rd_t rd
);

	lcsr_pkg::phase_t ph_q, ph_n;
	logic [lcsr_pkg::TICK_W-1:0] tc_q, tc_n, tc_inc, half_ext;
	logic [lcsr_pkg::RAW_BITS-1:0] sh_q, sh_n;
	logic [lcsr_pkg::BIT_CNT_W-1:0] bc_q, bc_n;
	logic done;

	always_comb begin
		ph_n = ph_q;
		tc_n = tc_q;
		sh_n = sh_q;
		bc_n = bc_q;
		done = 1'b0;
		tc_inc = tc_q + 1'b1;
		// A half period of zero behaves as one tick.
		half_ext = (half_period_ticks == '0) ? lcsr_pkg::TICK_W'(1)
			: lcsr_pkg::TICK_W'(half_period_ticks);
		unique case (ph_q)
			lcsr_pkg::PH_IDLE: begin
				if (!dout) begin
					sh_n = '0;
					bc_n = '0;
					tc_n = '0;
					ph_n = lcsr_pkg::PH_SETTLE;
				end
			end
			lcsr_pkg::PH_SETTLE: begin
				if (tc_q >= settle_ticks) begin
					tc_n = '0;
					ph_n = lcsr_pkg::PH_HIGH;
				end else begin
					tc_n = tc_inc;
				end
			end
			lcsr_pkg::PH_HIGH: begin
				tc_n = tc_inc;
				if (tc_inc >= half_ext) begin
					tc_n = '0;
					ph_n = lcsr_pkg::PH_LOW;
				end
			end
			lcsr_pkg::PH_LOW: begin
				// The bit is sampled on the first tick after the clock falls.
				if (tc_q == '0) begin
					sh_n = {sh_q[lcsr_pkg::RAW_BITS-2:0], dout};
					bc_n = bc_q + 1'b1;
				end
				tc_n = tc_inc;
				if (tc_inc >= half_ext) begin
					tc_n = '0;
					ph_n = (bc_n >= lcsr_pkg::BIT_CNT_W'(lcsr_pkg::RAW_BITS))
						? lcsr_pkg::PH_PULSE : lcsr_pkg::PH_HIGH;
				end
			end
			lcsr_pkg::PH_PULSE: begin
				tc_n = tc_inc;
				if (tc_inc >= half_ext) begin
					tc_n = '0;
					ph_n = lcsr_pkg::PH_IDLE;
					done = 1'b1;
				end
			end
			default: begin
				ph_n = lcsr_pkg::PH_IDLE;
				tc_n = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= lcsr_pkg::PH_IDLE;
			tc_q <= '0;
			sh_q <= '0;
			bc_q <= '0;
		end else if (tick) begin
			ph_q <= ph_n;
			tc_q <= tc_n;
			sh_q <= sh_n;
			bc_q <= bc_n;
		end
	end

	always_comb begin
		rd.sck = (ph_n == lcsr_pkg::PH_HIGH) || (ph_n == lcsr_pkg::PH_PULSE);
		rd.done = done;
		rd.raw = sh_q;
	end

endmodule

FILE: test/tb.sv
module tb;

	localparam int RAW_BITS = lcsr_pkg::RAW_BITS;
	localparam int WEIGHT_W = lcsr_pkg::WEIGHT_W;
	localparam int TICK_W = lcsr_pkg::TICK_W;
	localparam int CFG_IDX_W = lcsr_pkg::CFG_IDX_W;
	localparam int CFG_DATA_W = lcsr_pkg::CFG_DATA_W;

	localparam int LIMIT_CYCLES = 2_000_000;
	localparam int TOTAL_TICKS = 1300;
	localparam longint WEIGHT_FLOOR = -(longint'(1) << (WEIGHT_W - 1));
	localparam longint RAW_MAX = (longint'(1) << RAW_BITS) - 1;

	typedef struct {
		logic sck;
		logic done;
		logic [RAW_BITS-1:0] raw;
		logic tare;
		logic signed [WEIGHT_W-1:0] weight;
	} tick_result_t;

	// Tracks the reader's sequencer, tare and weight state and owes one result per tick.
	class scale_tracker;
		logic [lcsr_pkg::HALF_W-1:0] half_ticks;
		logic [lcsr_pkg::SETTLE_W-1:0] settle;
		logic [lcsr_pkg::TLIM_W-1:0] tare_lim;
		logic [lcsr_pkg::COEF_W-1:0] coef;
		logic [lcsr_pkg::WLIM_W-1:0] wlim;
		bit tare_armed;
		logic [RAW_BITS-1:0] offset;
		logic [RAW_BITS-1:0] shifter;
		logic [RAW_BITS-1:0] last_raw;
		logic signed [WEIGHT_W-1:0] held;
		int unsigned bits_in;
		lcsr_pkg::phase_t ph;
		logic [TICK_W-1:0] ticks;
		tick_result_t owed[$];
		int errors;

		function new();
			half_ticks = lcsr_pkg::HALF_RST;
			settle = lcsr_pkg::SETTLE_RST;
			tare_lim = lcsr_pkg::TLIM_RST;
			coef = lcsr_pkg::COEF_RST;
			wlim = lcsr_pkg::WLIM_RST;
			tare_armed = 1'b1;
			offset = '0;
			shifter = '0;
			last_raw = '0;
			held = '0;
			bits_in = 0;
			ph = lcsr_pkg::PH_IDLE;
			ticks = '0;
			errors = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				lcsr_pkg::CFG_HALF: half_ticks = val[lcsr_pkg::HALF_W-1:0];
				lcsr_pkg::CFG_SETTLE: settle = val[lcsr_pkg::SETTLE_W-1:0];
				lcsr_pkg::CFG_TLIM: tare_lim = val[lcsr_pkg::TLIM_W-1:0];
				lcsr_pkg::CFG_COEF: coef = val[lcsr_pkg::COEF_W-1:0];
				lcsr_pkg::CFG_WLIM: wlim = val[lcsr_pkg::WLIM_W-1:0];
				default: ;
			endcase
		endfunction

		function bit idle();
			return ph == lcsr_pkg::PH_IDLE;
		endfunction

		function bit next_is_sample();
			return ph == lcsr_pkg::PH_LOW && ticks == '0;
		endfunction

		function int pending();
			return owed.size();
		endfunction

		function void take_tick(logic d);
			logic [TICK_W-1:0] span;
			logic done;
			logic tared;
			longint diff;
			longint dv;
			longint q;
			tick_result_t r;
			span = (half_ticks == '0) ? TICK_W'(1) : TICK_W'(half_ticks);
			done = 1'b0;
			tared = 1'b0;
			case (ph)
				lcsr_pkg::PH_IDLE: begin
					if (!d) begin
						shifter = '0;
						bits_in = 0;
						ticks = '0;
						ph = lcsr_pkg::PH_SETTLE;
					end
				end
				lcsr_pkg::PH_SETTLE: begin
					if (ticks >= settle) begin
						ticks = '0;
						ph = lcsr_pkg::PH_HIGH;
					end else begin
						ticks = ticks + 1'b1;
					end
				end
				lcsr_pkg::PH_HIGH: begin
					ticks = ticks + 1'b1;
					if (ticks >= span) begin
						ticks = '0;
						ph = lcsr_pkg::PH_LOW;
					end
				end
				lcsr_pkg::PH_LOW: begin
					if (ticks == '0) begin
						shifter = {shifter[RAW_BITS-2:0], d};
						bits_in++;
					end
					ticks = ticks + 1'b1;
					if (ticks >= span) begin
						ticks = '0;
						ph = (bits_in >= RAW_BITS) ? lcsr_pkg::PH_PULSE : lcsr_pkg::PH_HIGH;
					end
				end
				lcsr_pkg::PH_PULSE: begin
					ticks = ticks + 1'b1;
					if (ticks >= span) begin
						ticks = '0;
						ph = lcsr_pkg::PH_IDLE;
						done = 1'b1;
						last_raw = shifter;
						if (tare_armed && shifter < tare_lim) begin
							tare_armed = 1'b0;
							offset = shifter;
							tared = 1'b1;
						end else begin
							diff = longint'(shifter) - longint'(offset) + lcsr_pkg::ROUND_BIAS;
							dv = (coef == '0) ? 1 : longint'(coef);
							q = diff / dv;
							if (q < WEIGHT_FLOOR)
								q = WEIGHT_FLOOR;
							if (q < longint'(wlim))
								held = WEIGHT_W'(q);
						end
					end
				end
				default: begin
					ph = lcsr_pkg::PH_IDLE;
					ticks = '0;
				end
			endcase
			r.sck = (ph == lcsr_pkg::PH_HIGH || ph == lcsr_pkg::PH_PULSE);
			r.done = done;
			r.raw = last_raw;
			r.tare = tared;
			r.weight = held;
			owed.push_back(r);
		endfunction

		function void report_miss(string what, longint want, longint got);
			errors++;
			$display("%0t: %s expected %0d, got %0d", $time, what, want, got);
		endfunction

		function void check_tick(tick_result_t got);
			tick_result_t want;
			if (owed.size() == 0) begin
				errors++;
				$display("%0t: result beat with nothing expected, raw %0d weight %0d",
					$time, got.raw, got.weight);
				return;
			end
			want = owed.pop_front();
			if (got.sck !== want.sck)
				report_miss("sck", want.sck, got.sck);
			if (got.done !== want.done)
				report_miss("sample_done", want.done, got.done);
			if (got.raw !== want.raw)
				report_miss("raw_code", want.raw, got.raw);
			if (got.tare !== want.tare)
				report_miss("tare_taken", want.tare, got.tare);
			if (got.weight !== want.weight)
				report_miss("weight", want.weight, got.weight);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic dout = 1'b1;
	logic out_valid;
	logic out_ready = 1'b0;
	logic sck;
	logic sample_done;
	logic [RAW_BITS-1:0] raw_code;
	logic tare_taken;
	logic signed [WEIGHT_W-1:0] weight;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	scale_tracker sb = new();
	bit calm = 1'b0;
	int sent_ticks = 0;
	int cycles = 0;

	load_cell_serial_reader_tare_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.dout(dout),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sck(sck),
		.sample_done(sample_done),
		.raw_code(raw_code),
		.tare_taken(tare_taken),
		.weight(weight),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT_CYCLES) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_ready <= calm || ($urandom_range(0, 99) >= 14);
	end

	always @(posedge clk) begin
		tick_result_t seen;
		if (arst_n && out_valid && out_ready) begin
			seen.sck = sck;
			seen.done = sample_done;
			seen.raw = raw_code;
			seen.tare = tare_taken;
			seen.weight = weight;
			sb.check_tick(seen);
		end
	end

	// Sends one tick beat, sometimes after a short gap, and returns at the edge that takes it.
	task automatic send_tick(input logic d);
		if (!calm && $urandom_range(0, 99) < 14) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		dout <= d;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sent_ticks++;
		sb.take_tick(d);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.set_reg(idx, val);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Starts a reading if the sequencer is idle, then feeds the bits of raw on the sampling
	// ticks and noise elsewhere, until the reading ends or upto bits have been taken.
	task automatic drive_reading(input logic [RAW_BITS-1:0] raw, input int upto);
		if (sb.idle()) begin
			repeat ($urandom_range(0, 2)) send_tick(1'b1);
			send_tick(1'b0);
		end
		while (!sb.idle() && sb.bits_in < upto) begin
			if (sb.next_is_sample())
				send_tick(raw[RAW_BITS - 1 - sb.bits_in]);
			else
				send_tick(1'($urandom_range(0, 1)));
		end
	endtask

	function automatic logic [CFG_DATA_W-1:0] pick_setting(lcsr_pkg::cfg_idx_t idx);
		case (idx)
			lcsr_pkg::CFG_HALF: return ($urandom_range(0, 9) == 0)
				? CFG_DATA_W'($urandom_range(0, 3)) : CFG_DATA_W'($urandom_range(1, 2));
			lcsr_pkg::CFG_SETTLE: return ($urandom_range(0, 9) == 0)
				? CFG_DATA_W'($urandom_range(5, 60)) : CFG_DATA_W'($urandom_range(0, 4));
			lcsr_pkg::CFG_TLIM: return CFG_DATA_W'($urandom);
			lcsr_pkg::CFG_COEF: begin
				case ($urandom_range(0, 4))
					0: return '0;
					1: return CFG_DATA_W'(1);
					2: return CFG_DATA_W'($urandom_range(2, 500));
					3: return CFG_DATA_W'(16'hFFFF);
					default: return CFG_DATA_W'($urandom_range(1, 16'hFFFF));
				endcase
			end
			default: begin
				case ($urandom_range(0, 3))
					0: return '0;
					1: return CFG_DATA_W'(15'h7FFF);
					default: return CFG_DATA_W'($urandom_range(0, 15'h7FFF));
				endcase
			end
		endcase
	endfunction

	// Readings are random, zero, full scale, near the tare, or near the weight limit so both sides of it occur.
	function automatic logic [RAW_BITS-1:0] pick_raw();
		longint v;
		longint dv;
		dv = (sb.coef == '0) ? 1 : longint'(sb.coef);
		case ($urandom_range(0, 5))
			0: v = longint'($urandom) & RAW_MAX;
			1: v = 0;
			2: v = RAW_MAX;
			3, 4: v = longint'(sb.offset) + $urandom_range(0, 20000) - 10000;
			default: v = longint'(sb.offset) - lcsr_pkg::ROUND_BIAS + dv * longint'(sb.wlim)
				+ $urandom_range(0, 2 * dv) - dv;
		endcase
		if (v < 0)
			v = 0;
		if (v > RAW_MAX)
			v = RAW_MAX;
		return RAW_BITS'(v);
	endfunction

	initial begin
		int n;
		lcsr_pkg::cfg_idx_t idx;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: a full-scale reading is above the tare limit and too heavy to hold.
		drive_reading({RAW_BITS{1'b1}}, RAW_BITS + 1);

		drain();
		write_reg(lcsr_pkg::CFG_HALF, 24'h5A5A01);
		write_reg(lcsr_pkg::CFG_SETTLE, '0);
		write_reg(lcsr_pkg::CFG_TLIM, 24'd1000);
		write_reg(lcsr_pkg::CFG_COEF, 24'd1);
		write_reg(lcsr_pkg::CFG_WLIM, 24'hFF7FFF);
		for (int i = int'(lcsr_pkg::CFG_WLIM) + 1; i < (1 << CFG_IDX_W); i++)
			write_reg(CFG_IDX_W'(i), 24'd7);

		// A reading equal to the tare limit is a weight; one below it becomes the tare.
		drive_reading(24'd1000, RAW_BITS + 1);
		drive_reading(24'd999, RAW_BITS + 1);
		drive_reading(24'd0, RAW_BITS + 1);

		drain();
		write_reg(lcsr_pkg::CFG_COEF, '0);
		drive_reading(24'd30000, RAW_BITS + 1);

		drain();
		write_reg(lcsr_pkg::CFG_HALF, '0);
		write_reg(lcsr_pkg::CFG_COEF, 24'd7);
		drive_reading(24'd0, RAW_BITS + 1);

		drain();
		write_reg(lcsr_pkg::CFG_WLIM, '0);
		drive_reading(24'd999, RAW_BITS + 1);
		drive_reading(24'd500, RAW_BITS + 1);

		drain();
		write_reg(lcsr_pkg::CFG_COEF, 24'hFFFF);
		write_reg(lcsr_pkg::CFG_WLIM, 24'h7FFF);
		drive_reading({RAW_BITS{1'b1}}, RAW_BITS + 1);

		// Change the bit timing halfway through a reading.
		drive_reading(24'hA5C3F0, 12);
		drain();
		write_reg(lcsr_pkg::CFG_HALF, 24'd3);
		write_reg(lcsr_pkg::CFG_COEF, 24'd415);
		drive_reading(24'hA5C3F0, RAW_BITS + 1);

		drain();
		write_reg(lcsr_pkg::CFG_HALF, 24'd2);
		drive_reading(24'h5A3C0F, RAW_BITS + 1);

		drain();
		write_reg(lcsr_pkg::CFG_HALF, 24'd1);
		write_reg(lcsr_pkg::CFG_SETTLE, 24'd20);
		write_reg(lcsr_pkg::CFG_TLIM, 24'hFFFFFF);
		drive_reading(24'h00F00F, RAW_BITS + 1);

		drain();
		write_reg(lcsr_pkg::CFG_SETTLE, 24'd2);
		write_reg(lcsr_pkg::CFG_TLIM, '0);

		n = 0;
		while (sent_ticks < TOTAL_TICKS) begin
			n++;
			calm = (n >= 2 && n < 5);
			if ($urandom_range(0, 2) == 0) begin
				drain();
				repeat ($urandom_range(1, 3)) begin
					idx = lcsr_pkg::cfg_idx_t'($urandom_range(int'(lcsr_pkg::CFG_HALF),
						int'(lcsr_pkg::CFG_WLIM)));
					write_reg(idx, pick_setting(idx));
				end
			end
			if ($urandom_range(0, 9) == 0) begin
				logic [RAW_BITS-1:0] raw;
				raw = pick_raw();
				drive_reading(raw, $urandom_range(1, RAW_BITS - 1));
				drain();
				idx = lcsr_pkg::cfg_idx_t'($urandom_range(int'(lcsr_pkg::CFG_HALF),
					int'(lcsr_pkg::CFG_WLIM)));
				write_reg(idx, pick_setting(idx));
				drive_reading(raw, RAW_BITS + 1);
			end else begin
				drive_reading(pick_raw(), RAW_BITS + 1);
			end
		end
		calm = 1'b0;

		drain();
		repeat (40) @(posedge clk);
		if (sb.errors == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/lcsr_pkg.sv
rtl/lcsr_div.sv
rtl/lcsr_seq.sv
rtl/load_cell_serial_reader_tare_top.sv
test/tb.sv
